// ===== rtl/core/mdf_pkg.sv =====
package mdf_pkg;

    // screen geometry defaults
    localparam int SCREEN_COLS_DEF = 128;
    localparam int SCREEN_ROWS_DEF = 64;

    // APB configuration port
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    // input command codes
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    // fade level bounds
    localparam logic [2:0] LEVEL_MIN      = 3'd1;
    localparam logic [2:0] LEVEL_MAX      = 3'd5;
    localparam logic [2:0] LEVEL_THIN_MIN = 3'd2;
    localparam logic [2:0] LEVEL_THIN_MAX = 3'd4;

    typedef enum logic [2:0] {
        REG_DIM_LEVEL   = 3'd0,
        REG_REGION_LEFT = 3'd1,
        REG_REGION_TOP  = 3'd2,
        REG_REGION_COLS = 3'd3,
        REG_REGION_ROWS = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [2:0] dim_level;
        logic [6:0] region_left;
        logic [5:0] region_top;
        logic [7:0] region_cols;
        logic [6:0] region_rows;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        dim_level:   3'd4,
        region_left: 7'd0,
        region_top:  6'd0,
        region_cols: 8'd128,
        region_rows: 7'd64
    };

    // 2x2 ordered dither: bit {gy,gx} set means the pixel is a clear candidate
    function automatic logic dither_hit(input logic [2:0] level, input logic gy,
                                        input logic gx);
        logic [3:0] mask;
        case (level)
            3'd1:    mask = 4'h0;
            3'd2:    mask = 4'h1;
            3'd3:    mask = 4'h9;
            3'd4:    mask = 4'hD;
            3'd5:    mask = 4'hF;
            default: mask = 4'h0;
        endcase
        return mask[{gy, gx}];
    endfunction

    function automatic logic [1:0] count3(input logic [2:0] v);
        return {1'b0, v[0]} + {1'b0, v[1]} + {1'b0, v[2]};
    endfunction

endpackage

// ===== rtl/core/mdf_apb_regs.sv =====
module mdf_apb_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mdf_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [mdf_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [mdf_pkg::APB_DATA_W-1:0]    prdata,
    output mdf_pkg::cfg_t                     cfg
);

    mdf_pkg::cfg_t     cfg_reg;
    mdf_pkg::cfg_t     cfg_next;
    mdf_pkg::reg_idx_t idx;
    logic              wr_en;

    assign idx   = mdf_pkg::reg_idx_t'(paddr[mdf_pkg::APB_ADDR_W-1:2]);
    assign wr_en = psel && penable && pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                mdf_pkg::REG_DIM_LEVEL:   cfg_next.dim_level   = pwdata[2:0];
                mdf_pkg::REG_REGION_LEFT: cfg_next.region_left = pwdata[6:0];
                mdf_pkg::REG_REGION_TOP:  cfg_next.region_top  = pwdata[5:0];
                mdf_pkg::REG_REGION_COLS: cfg_next.region_cols = pwdata[7:0];
                mdf_pkg::REG_REGION_ROWS: cfg_next.region_rows = pwdata[6:0];
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            mdf_pkg::REG_DIM_LEVEL:   prdata = {29'd0, cfg_reg.dim_level};
            mdf_pkg::REG_REGION_LEFT: prdata = {25'd0, cfg_reg.region_left};
            mdf_pkg::REG_REGION_TOP:  prdata = {26'd0, cfg_reg.region_top};
            mdf_pkg::REG_REGION_COLS: prdata = {24'd0, cfg_reg.region_cols};
            mdf_pkg::REG_REGION_ROWS: prdata = {25'd0, cfg_reg.region_rows};
            default:                  prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= mdf_pkg::CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/core/mdf_decide.sv =====
module mdf_decide #(
    parameter int COL_W = $clog2(mdf_pkg::SCREEN_COLS_DEF),
    parameter int ROW_W = $clog2(mdf_pkg::SCREEN_ROWS_DEF)
) (
    input  mdf_pkg::cfg_t    cfg,
    input  logic [COL_W-1:0] col,
    input  logic [ROW_W-1:0] row,
    input  logic [2:0]       lc,
    input  logic [2:0]       cc,
    input  logic [2:0]       rc,
    output logic             pixel
);

    localparam int CX_W = ((COL_W > 8) ? COL_W : 8) + 1;
    localparam int RY_W = ((ROW_W > 7) ? ROW_W : 7) + 1;

    logic [CX_W-1:0] cx;
    logic [CX_W-1:0] cl;
    logic [CX_W-1:0] coff;
    logic [RY_W-1:0] ry;
    logic [RY_W-1:0] rt;
    logic [RY_W-1:0] roff;
    logic            in_x;
    logic            in_y;
    logic            level_ok;
    logic            level_thin;
    logic            pattern;
    logic [3:0]      total;
    logic            col0;
    logic [1:0]      cnt_a;
    logic [1:0]      cnt_b;
    logic [1:0]      cnt_d;
    logic            thin;
    logic            spared;
    logic            clear;

    always_comb
    begin
        cx   = CX_W'(col);
        cl   = CX_W'(cfg.region_left);
        coff = cx - cl;
        ry   = RY_W'(row);
        rt   = RY_W'(cfg.region_top);
        roff = ry - rt;
        in_x = (cx >= cl) && (coff < CX_W'(cfg.region_cols));
        in_y = (ry >= rt) && (roff < RY_W'(cfg.region_rows));

        level_ok   = (cfg.dim_level >= mdf_pkg::LEVEL_MIN) &&
                     (cfg.dim_level <= mdf_pkg::LEVEL_MAX);
        level_thin = (cfg.dim_level >= mdf_pkg::LEVEL_THIN_MIN) &&
                     (cfg.dim_level <= mdf_pkg::LEVEL_THIN_MAX);

        // dither phase is relative to the region origin
        pattern = mdf_pkg::dither_hit(cfg.dim_level, row[0] ^ cfg.region_top[0],
                                      col[0] ^ cfg.region_left[0]);

        total = 4'(mdf_pkg::count3(lc)) + 4'(mdf_pkg::count3(cc)) +
                4'(mdf_pkg::count3(rc));

        // left screen edge: window columns counted one place over
        col0  = (col == '0);
        cnt_a = col0 ? mdf_pkg::count3(cc) : mdf_pkg::count3(lc);
        cnt_b = col0 ? mdf_pkg::count3(rc) : mdf_pkg::count3(cc);
        cnt_d = col0 ? 2'd0 : mdf_pkg::count3(rc);
        thin  = (cnt_b >= 2'd2) && ((3'(cnt_a) + 3'(cnt_d)) <= 3'd1);

        spared = level_thin && thin && ((row[0] ^ cfg.dim_level[0]) == 1'b0);
        clear  = level_ok && in_x && in_y && pattern && (total >= 4'd2) && !spared;
        pixel  = cc[1] && !clear;
    end

endmodule

// ===== rtl/core/mono_dither_fade_filter.sv =====
// Ordered-dither fade for a 1-bit screen of SCREEN_COLS x SCREEN_ROWS pixels.
// Pixels (cmd = pixel) enter in raster order, one word per clock unless
// stalled; each pixel leaves faded, SCREEN_COLS + 1 input words later, tagged
// with its column, row and a frame_last flag on the final pixel. After the
// last real pixel of a frame, SCREEN_COLS + 1 more words (flush, or pixels,
// whose values are dropped) drain the frame; a flush sent before that is
// taken and ignored. A new frame starts right after the frame_last pixel.
// The block takes one word per clock unless stalled: each word but an early
// flush does one read and one write of the line memory (SCREEN_COLS x 2
// bits, holding the two previous rows per column), the read in the accept
// cycle and the write back as stage B moves on, so the rate is set by that
// single memory port pair. Stage B feeds a registered output stage that lets
// the next word in while a result waits for out_ready. No clearing pass is
// needed after reset: rows not yet written in the current frame are masked
// at the read. Fade level and region sit in APB registers at byte offsets
// 0x00..0x10 and should be written only while the block is idle.
module mono_dither_fade_filter #(
    parameter int SCREEN_COLS = mdf_pkg::SCREEN_COLS_DEF,
    parameter int SCREEN_ROWS = mdf_pkg::SCREEN_ROWS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,

    // APB configuration
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [mdf_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [mdf_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [mdf_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready,

    // pixel input
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             cmd,
    input  logic                             pixel_in,

    // faded output
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             pixel_out,
    output logic [$clog2(SCREEN_COLS)-1:0]   out_col,
    output logic [$clog2(SCREEN_ROWS)-1:0]   out_row,
    output logic                             frame_last
);

    localparam int COL_W = $clog2(SCREEN_COLS);
    localparam int ROW_W = $clog2(SCREEN_ROWS);
    localparam int RIN_W = $clog2(SCREEN_ROWS + 2);   // input row runs into drain rows

    localparam logic [COL_W-1:0] COL_LAST  = COL_W'(SCREEN_COLS - 1);
    localparam logic [RIN_W-1:0] ROW_DRAIN = RIN_W'(SCREEN_ROWS);
    localparam logic [RIN_W-1:0] ROW_END   = RIN_W'(SCREEN_ROWS + 1);

    mdf_pkg::cfg_t cfg;

    assign pready = 1'b1;

    mdf_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    // ------------------------------------------------------------------
    // Stage A: accept, raster position, memory read
    // ------------------------------------------------------------------
    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [RIN_W-1:0] row_reg;
    logic [RIN_W-1:0] row_next;

    logic             in_fire;
    logic             drain;
    logic             a_take;       // word that does work (not an early flush)
    logic             a_pix;
    logic             col_zero;
    logic             a_emit;
    logic             a_last;
    logic             a_g1;         // row r-1 holds data of this frame
    logic             a_g0;         // row r-2 holds data of this frame
    logic [RIN_W-1:0] row_m1;
    logic [RIN_W-1:0] row_m2;
    logic [COL_W-1:0] a_ecol;
    logic [ROW_W-1:0] a_erow;

    always_comb
    begin
        in_fire  = in_valid && in_ready;
        drain    = (row_reg >= ROW_DRAIN);
        a_take   = in_fire && !((cmd == mdf_pkg::CMD_FLUSH) && !drain);
        a_pix    = !drain && pixel_in;
        col_zero = (col_reg == '0);
        // column 0 finishes the row two up; other columns emit one row up, one left
        a_emit   = col_zero ? (row_reg >= RIN_W'(2)) : (row_reg >= RIN_W'(1));
        a_last   = col_zero && (row_reg == ROW_END);
        a_g1     = (row_reg >= RIN_W'(1)) && (row_reg <= ROW_DRAIN);
        a_g0     = (row_reg >= RIN_W'(2)) && (row_reg <= ROW_END);
        row_m1   = row_reg - RIN_W'(1);
        row_m2   = row_reg - RIN_W'(2);
        a_ecol   = col_zero ? COL_LAST : (col_reg - COL_W'(1));
        a_erow   = col_zero ? row_m2[ROW_W-1:0] : row_m1[ROW_W-1:0];

        col_next = col_reg;
        row_next = row_reg;
        if (a_take)
        begin
            if (a_last)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (col_reg == COL_LAST)
            begin
                col_next = '0;
                row_next = row_reg + RIN_W'(1);
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage B: window shift, fade decision, memory write back
    // ------------------------------------------------------------------
    logic             b_valid_reg;
    logic             b_valid_next;
    logic             b_emit_reg;
    logic             b_last_reg;
    logic             b_edge_reg;
    logic             b_pix_reg;
    logic             b_g1_reg;
    logic             b_g0_reg;
    logic [COL_W-1:0] b_addr_reg;
    logic [COL_W-1:0] b_ecol_reg;
    logic [ROW_W-1:0] b_erow_reg;

    logic [8:0]       win_reg;      // three columns of three rows, newest on top
    logic [8:0]       win_next;
    logic [2:0]       newcol;
    logic [8:0]       win_shift;
    logic [2:0]       lc;
    logic [2:0]       cc;
    logic [2:0]       rc;
    logic             fade_pix;
    logic             b_go;

    // Line memory: word per column = {row r-1, row r-2}. Read and write of
    // one column are SCREEN_COLS words apart, so no forwarding; at a frame
    // wrap the stale read of column 0 is masked by the row gates.
    logic [1:0]       line_mem [SCREEN_COLS];
    logic [1:0]       line_rd_reg;

    // output stage
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             pixel_out_reg;
    logic [COL_W-1:0] out_col_reg;
    logic [ROW_W-1:0] out_row_reg;
    logic             frame_last_reg;

    always_comb
    begin
        b_go     = b_valid_reg && (!b_emit_reg || !out_valid_reg || out_ready);
        in_ready = !b_valid_reg || b_go;

        newcol    = {b_pix_reg, line_rd_reg[1] & b_g1_reg, line_rd_reg[0] & b_g0_reg};
        win_shift = {newcol, win_reg[8:3]};

        if (b_edge_reg)
        begin
            // last pixel of a row: window before the shift, nothing to the right
            lc = win_reg[5:3];
            cc = win_reg[8:6];
            rc = 3'd0;
        end
        else
        begin
            // first pixel of a row: left column still holds the previous row
            lc = (b_ecol_reg == '0) ? 3'd0 : win_shift[2:0];
            cc = win_shift[5:3];
            rc = win_shift[8:6];
        end

        win_next = win_reg;
        if (b_go)
        begin
            win_next = b_last_reg ? 9'd0 : win_shift;
        end

        b_valid_next = b_valid_reg;
        if (a_take)
        begin
            b_valid_next = 1'b1;
        end
        else if (b_go)
        begin
            b_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (b_go && b_emit_reg)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    mdf_decide #(
        .COL_W (COL_W),
        .ROW_W (ROW_W)
    ) u_decide (
        .cfg   (cfg),
        .col   (b_ecol_reg),
        .row   (b_erow_reg),
        .lc    (lc),
        .cc    (cc),
        .rc    (rc),
        .pixel (fade_pix)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            b_valid_reg   <= 1'b0;
            win_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            b_valid_reg   <= b_valid_next;
            win_reg       <= win_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // stage B payload
    always_ff @(posedge clk)
    begin
        if (a_take)
        begin
            b_emit_reg <= a_emit;
            b_last_reg <= a_last;
            b_edge_reg <= col_zero;
            b_pix_reg  <= a_pix;
            b_g1_reg   <= a_g1;
            b_g0_reg   <= a_g0;
            b_addr_reg <= col_reg;
            b_ecol_reg <= a_ecol;
            b_erow_reg <= a_erow;
        end
    end

    // line memory, registered read
    always_ff @(posedge clk)
    begin
        if (a_take)
        begin
            line_rd_reg <= line_mem[col_reg];
        end
        if (b_go)
        begin
            line_mem[b_addr_reg] <= {b_pix_reg, line_rd_reg[1]};
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (b_go && b_emit_reg)
        begin
            pixel_out_reg  <= fade_pix;
            out_col_reg    <= b_ecol_reg;
            out_row_reg    <= b_erow_reg;
            frame_last_reg <= b_last_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign pixel_out  = pixel_out_reg;
    assign out_col    = out_col_reg;
    assign out_row    = out_row_reg;
    assign frame_last = frame_last_reg;

endmodule

// ===== rtl/core/mdf_checker.sv =====
module mdf_checker #(
    parameter int SCREEN_COLS = mdf_pkg::SCREEN_COLS_DEF,
    parameter int SCREEN_ROWS = mdf_pkg::SCREEN_ROWS_DEF
) (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic                           pixel_out,
    input logic [$clog2(SCREEN_COLS)-1:0] out_col,
    input logic [$clog2(SCREEN_ROWS)-1:0] out_row,
    input logic                           frame_last
);

    localparam int COL_W = $clog2(SCREEN_COLS);
    localparam int ROW_W = $clog2(SCREEN_ROWS);

    // nothing comes out right after reset
    a_no_word_after_reset: assert property (@(posedge clk)
        !$past(rst_n) |-> !out_valid)
        else $error("output word right after reset");

    // frame end lands on the bottom-right pixel
    a_last_position: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && frame_last) |->
            (out_col == COL_W'(SCREEN_COLS - 1)) && (out_row == ROW_W'(SCREEN_ROWS - 1)))
        else $error("frame_last away from the last pixel");

    // emitted coordinates stay on the screen
    a_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (int'(out_col) < SCREEN_COLS) && (int'(out_row) < SCREEN_ROWS))
        else $error("output coordinate off screen");

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("out_valid dropped while stalled");

    a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            ($stable(pixel_out) && $stable(out_col) && $stable(out_row) &&
             $stable(frame_last)))
        else $error("output word changed while stalled");

endmodule

bind mono_dither_fade_filter mdf_checker #(
    .SCREEN_COLS (SCREEN_COLS),
    .SCREEN_ROWS (SCREEN_ROWS)
) u_mdf_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .pixel_out  (pixel_out),
    .out_col    (out_col),
    .out_row    (out_row),
    .frame_last (frame_last)
);
